@@ hw/rtl/intra_4x4_block_predictor_core_macros.svh @@
// Assertion macros used by the predictor controller RTL
`ifndef INTRA_4X4_BLOCK_PREDICTOR_CORE_MACROS_SVH
`define INTRA_4X4_BLOCK_PREDICTOR_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define IBP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define IBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ibp_pkg.sv @@
`timescale 1ns / 1ps
package ibp_pkg;

  localparam int unsigned NumSlots = 14;
  localparam int unsigned SlotW    = 4;

  typedef enum logic [3:0] {
    MODE_DC   = 4'd0,
    MODE_TM   = 4'd1,
    MODE_V    = 4'd2,
    MODE_H    = 4'd3,
    MODE_D45  = 4'd4,
    MODE_D135 = 4'd5,
    MODE_D117 = 4'd6,
    MODE_D63  = 4'd7,
    MODE_D153 = 4'd8,
    MODE_D27  = 4'd9
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EDGE,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;      // write pixel into edge store
    logic       capture;   // latch predict fields
    logic       build;     // form edges and DC
    logic       advance;   // step pixel counter
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic last_pixel;
  } stat_t;

  function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b} + 9'd1;
    return s[8:1];
  endfunction

  function automatic logic [7:0] avg3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [9:0] s;
    s = {2'b0, a} + {1'b0, b, 1'b0} + {2'b0, c} + 10'd2;
    return s[9:2];
  endfunction

  function automatic logic [7:0] clip8(input logic signed [9:0] v);
    if (v < 0) return 8'd0;
    if (v > 10'sd255) return 8'd255;
    return v[7:0];
  endfunction

endpackage

@@ hw/rtl/ibp_ctrl.sv @@
`timescale 1ns / 1ps
module ibp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           action,
  output logic           out_valid,
  input  logic           out_ready,
  output ibp_pkg::ctrl_t ctrl,
  input  ibp_pkg::stat_t stat
);
  import ibp_pkg::*;
  `include "intra_4x4_block_predictor_core_macros.svh"

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    ctrl         = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (action) begin
            ctrl.capture = 1'b1;
            state_next   = ST_EDGE;
          end else begin
            ctrl.load = 1'b1;
          end
        end
      end
      ST_EDGE: begin
        ctrl.build = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          ctrl.advance = 1'b1;
          if (stat.last_pixel) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `IBP_ASSERT_IMP(a_no_in_while_busy, clk, rst, state != ST_IDLE, !in_ready, "input taken while busy")
  `IBP_ASSERT_NEXT(a_build_then_emit, clk, rst, state == ST_EDGE, state == ST_EMIT, "edge build not followed by emit")
  `IBP_ASSERT_NEXT(a_done_idle, clk, rst, out_valid && out_ready && stat.last_pixel, state == ST_IDLE, "no return to idle after last pixel")

endmodule

@@ hw/rtl/ibp_dp.sv @@
`timescale 1ns / 1ps
module ibp_dp (
  input  logic           clk,
  input  logic           rst,
  input  ibp_pkg::ctrl_t ctrl,
  output ibp_pkg::stat_t stat,
  input  logic [3:0]     edge_slot,
  input  logic [7:0]     pixel_value,
  input  logic [3:0]     mode,
  input  logic [3:0]     block_index,
  input  logic           up_ok,
  input  logic           left_ok,
  input  logic           right_ok,
  input  logic [1:0]     macroblock_index,
  input  logic [1:0]     superblock_index,
  output logic [7:0]     predicted_pixel,
  output logic [1:0]     row,
  output logic [1:0]     column,
  output logic           last
);
  import ibp_pkg::*;

  logic [7:0] store [NumSlots];
  logic [3:0] mode_q, blk_q;
  logic       up_q, lf_q, rt_q;
  logic [1:0] mb_q, sb_q;
  logic [7:0] left_q [4];
  logic [7:0] above_q [8];
  logic [7:0] tl_q, dc_q;
  logic [3:0] cnt;

  always_ff @(posedge clk) begin
    if (ctrl.load && edge_slot < SlotW'(NumSlots)) store[edge_slot] <= pixel_value;
    if (ctrl.capture) begin
      mode_q <= mode; blk_q <= block_index; up_q <= up_ok;
      lf_q <= left_ok; rt_q <= right_ok;
      mb_q <= macroblock_index; sb_q <= superblock_index;
    end
  end

  // edge build
  logic       top, lft, rgt, near;
  logic [7:0] lft_e [4];
  logic [7:0] abv_e [8];
  logic [7:0] tl_e, dc_e;
  logic [10:0] sum;
  always_comb begin
    top  = (blk_q[3:2] != 2'd0) || up_q;
    lft  = (blk_q[1:0] != 2'd0) || lf_q;
    rgt  = (blk_q[1:0] != 2'd3) || rt_q;
    near = (blk_q[1:0] != 2'd3) || (rgt && blk_q == 4'd3 &&
           ((mb_q != 2'd3 && sb_q != 2'd3) || (!mb_q[0] && sb_q == 2'd3)));
    for (int i = 0; i < 4; i++) lft_e[i] = lft ? store[i] : 8'd129;
    tl_e = (top && lft) ? store[12] : 8'd127;
    for (int i = 0; i < 8; i++) begin
      if (!top) abv_e[i] = 8'd127;
      else if (i < 4 || near) abv_e[i] = store[4 + i];
      else if (rgt) abv_e[i] = clip8($signed({2'b0, store[4 + i]})
                                     + $signed({2'b0, store[7]})
                                     - $signed({2'b0, store[13]}));
      else abv_e[i] = store[7];
    end
    sum = '0;
    if (top) for (int i = 0; i < 4; i++) sum = sum + 11'(abv_e[i]);
    if (lft) for (int i = 0; i < 4; i++) sum = sum + 11'(lft_e[i]);
    if (top && lft)      dc_e = 8'((sum + 11'd4) >> 3);
    else if (top || lft) dc_e = 8'((sum + 11'd2) >> 2);
    else                 dc_e = 8'd128;
  end

  always_ff @(posedge clk) begin
    if (ctrl.build) begin
      left_q <= lft_e; above_q <= abv_e; tl_q <= tl_e; dc_q <= dc_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.build) cnt <= '0;
    else if (ctrl.advance) cnt <= cnt + 4'd1;
  end

  // per-pixel kernel
  logic [7:0] p [9];
  logic [1:0] r, c;
  logic [2:0] k, k2;
  logic [7:0] px;
  always_comb begin
    r = cnt[3:2]; c = cnt[1:0];
    p[0] = left_q[3]; p[1] = left_q[2]; p[2] = left_q[1]; p[3] = left_q[0];
    p[4] = tl_q;
    for (int i = 0; i < 4; i++) p[5 + i] = above_q[i];
    k  = 3'(r) + 3'(c);
    k2 = (k > 3'd5) ? 3'd7 : k + 3'd2;
    px = 8'd128;
    case (mode_q)
      MODE_DC:  px = dc_q;
      MODE_TM:  px = clip8($signed({2'b0, above_q[c]}) - $signed({2'b0, tl_q})
                           + $signed({2'b0, left_q[r]}));
      MODE_V:   px = above_q[c];
      MODE_H:   px = left_q[r];
      MODE_D45: px = avg3(above_q[k], above_q[k + 3'd1], above_q[k2]);
      MODE_D135: begin
        k  = 3'(c) + 3'd3 - 3'(r);
        px = avg3(p[4'(k)], p[4'(k) + 4'd1], p[4'(k) + 4'd2]);
      end
      MODE_D117: begin
        case (cnt)
          4'd12: px = avg3(p[1], p[2], p[3]);
          4'd8:  px = avg3(p[2], p[3], p[4]);
          4'd13, 4'd4: px = avg3(p[3], p[4], p[5]);
          4'd9, 4'd0:  px = avg2(p[4], p[5]);
          4'd14, 4'd5: px = avg3(p[4], p[5], p[6]);
          4'd10, 4'd1: px = avg2(p[5], p[6]);
          4'd15, 4'd6: px = avg3(p[5], p[6], p[7]);
          4'd11, 4'd2: px = avg2(p[6], p[7]);
          4'd7:  px = avg3(p[6], p[7], p[8]);
          default: px = avg2(p[7], p[8]);
        endcase
      end
      MODE_D63: begin
        case (cnt)
          4'd0:  px = avg2(above_q[0], above_q[1]);
          4'd4:  px = avg3(above_q[0], above_q[1], above_q[2]);
          4'd8, 4'd1:  px = avg2(above_q[1], above_q[2]);
          4'd5, 4'd12: px = avg3(above_q[1], above_q[2], above_q[3]);
          4'd9, 4'd2:  px = avg2(above_q[2], above_q[3]);
          4'd13, 4'd6: px = avg3(above_q[2], above_q[3], above_q[4]);
          4'd3, 4'd10: px = avg2(above_q[3], above_q[4]);
          4'd7, 4'd14: px = avg3(above_q[3], above_q[4], above_q[5]);
          4'd11: px = avg3(above_q[4], above_q[5], above_q[6]);
          default: px = avg3(above_q[5], above_q[6], above_q[7]);
        endcase
      end
      MODE_D153: begin
        case (cnt)
          4'd12: px = avg2(p[0], p[1]);
          4'd13: px = avg3(p[0], p[1], p[2]);
          4'd8, 4'd14: px = avg2(p[1], p[2]);
          4'd9, 4'd15: px = avg3(p[1], p[2], p[3]);
          4'd10, 4'd4: px = avg2(p[2], p[3]);
          4'd11, 4'd5: px = avg3(p[2], p[3], p[4]);
          4'd6, 4'd0:  px = avg2(p[3], p[4]);
          4'd7, 4'd1:  px = avg3(p[3], p[4], p[5]);
          4'd2:  px = avg3(p[4], p[5], p[6]);
          default: px = avg3(p[5], p[6], p[7]);
        endcase
      end
      MODE_D27: begin
        case (cnt)
          4'd0:  px = avg2(left_q[0], left_q[1]);
          4'd1:  px = avg3(left_q[0], left_q[1], left_q[2]);
          4'd2, 4'd4: px = avg2(left_q[1], left_q[2]);
          4'd3, 4'd5: px = avg3(left_q[1], left_q[2], left_q[3]);
          4'd6, 4'd8: px = avg2(left_q[2], left_q[3]);
          4'd7, 4'd9: px = avg3(left_q[2], left_q[3], left_q[3]);
          default: px = left_q[3];
        endcase
      end
      default: px = 8'd128;
    endcase
  end

  assign predicted_pixel = px;
  assign row             = r;
  assign column          = c;
  assign last            = (cnt == 4'd15);
  assign stat.last_pixel = last;

endmodule

@@ hw/rtl/intra_4x4_block_predictor_core.sv @@
`timescale 1ns / 1ps
// Channel | signals                                              | transfer when
// in      | in_valid/in_ready, action, edge_slot .. superblock_index | in_valid & in_ready
// out     | out_valid/out_ready, predicted_pixel, row, column, last  | out_valid & out_ready
//
// A load writes the pixel into the edge store on transfer.
// A predict captures its fields on transfer, builds edges and DC in ST_EDGE,
// then makes 16 output transfers, one per cycle while out_ready holds.
// A 16-step pixel counter walks the outputs; one pixel kernel is shared.
// Reset clears only the controller and the pixel counter; the edge store is
// undefined until written. An out stall holds the counter and pixel.
module intra_4x4_block_predictor_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [3:0] edge_slot,
  input  logic [7:0] pixel_value,
  input  logic [3:0] mode,
  input  logic [3:0] block_index,
  input  logic       up_ok,
  input  logic       left_ok,
  input  logic       right_ok,
  input  logic [1:0] macroblock_index,
  input  logic [1:0] superblock_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] predicted_pixel,
  output logic [1:0] row,
  output logic [1:0] column,
  output logic       last
);
  import ibp_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // sequencer: idle, edge build, pixel emission
  ibp_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .action,
    .out_valid, .out_ready, .ctrl, .stat
  );

  // edge store, edge formation and per-pixel kernel
  ibp_dp u_dp (
    .clk, .rst, .ctrl, .stat, .edge_slot, .pixel_value, .mode, .block_index,
    .up_ok, .left_ok, .right_ok, .macroblock_index,
    .superblock_index, .predicted_pixel, .row, .column, .last
  );

endmodule
